[rtl/core/bps_pkg.sv]
package bps_pkg;

    // Default build values
    localparam int DEF_STEAM_PUMP_PCT = 30;
    localparam int DEF_TIME_BITS      = 32;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_BOILER_SP   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STEAM_SP    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BREW_PRESS  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BLOOM_FILL  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BLOOM_WAIT  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BLOOM_PRESS = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BREW_TIME   = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STEAM_MAX   = 3'd7;

    // Configuration reset values
    localparam logic [10:0] RST_BOILER_SP   = 11'd930;
    localparam logic [10:0] RST_STEAM_SP    = 11'd1400;
    localparam logic [7:0]  RST_BREW_PRESS  = 8'd90;
    localparam logic [7:0]  RST_STEAM_MAX   = 8'd20;

    // Fixed clean pressure, 9.0 bar
    localparam logic [7:0] CLEAN_PRESSURE = 8'd90;

    // Phase codes
    localparam logic [1:0] PH_OFF  = 2'd0;
    localparam logic [1:0] PH_FILL = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_BREW = 2'd3;

    // Mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_BREW  = 2'd1;
    localparam logic [1:0] MODE_CLEAN = 2'd2;
    localparam logic [1:0] MODE_STEAM = 2'd3;

    // Request payload
    typedef struct packed {
        logic [31:0] now_ms;
        logic        changed;
        logic        want_brew;
        logic        want_clean;
        logic        want_bloom;
        logic        want_auto;
        logic        steaming;
        logic        boiler_on;
    } in_t;

    // Result payload
    typedef struct packed {
        logic        valid_res;
        logic [1:0]  mode;
        logic [10:0] temp_set;
        logic [7:0]  press_set;
        logic [6:0]  pump_pct;
        logic        clear_bloom;
        logic        clear_auto;
        logic [1:0]  phase;
        logic [31:0] action_start_ms;
        logic [31:0] action_stop_ms;
        logic [31:0] last_shot_ms;
    } out_t;

    // Configuration register file contents
    typedef struct packed {
        logic [10:0] boiler_setpoint;
        logic [10:0] steam_setpoint;
        logic [7:0]  brew_pressure;
        logic [31:0] bloom_fill_ms;
        logic [31:0] bloom_wait_ms;
        logic [7:0]  bloom_pressure;
        logic [31:0] brew_time_ms;
        logic [7:0]  steam_press_cap;
    } cfg_t;

endpackage

[rtl/core/brew_phase_sequencer_unit.sv]
// Channel   | Signals                            | Direction | Notes
// ----------+------------------------------------+-----------+-----------------------------
// item      | item_valid, item_ready, item       | in        | one request per command/tick
// result    | result_valid, result_ready, result | out       | exactly one result per request
// config    | cfg_we, cfg_addr, cfg_wdata        | in        | write only
//
// One request per cycle sustained while the result side accepts. An accepted request
// sits in the input register, is decoded combinationally and lands in the result
// register once that register can take a new value; its result is offered from there.
// rst_n clears the phase state, time stamps and both pipeline valid bits; the
// configuration registers return to their default set points.
// A stalled result holds the result register and the request behind it; the
// input side frees as soon as the result register can take a new value.
module brew_phase_sequencer_unit #(
    parameter int STEAM_PUMP_PCT = bps_pkg::DEF_STEAM_PUMP_PCT,
    parameter int TIME_BITS      = bps_pkg::DEF_TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  bps_pkg::in_t                       item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output bps_pkg::out_t                      result,
    input  logic                               cfg_we,
    input  logic [bps_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [bps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import bps_pkg::*;

    logic  in_valid_reg;
    in_t   in_data_reg;
    logic  out_valid_reg;
    out_t  out_data_reg;
    cfg_t  cfg_reg;
    out_t  step_res;
    logic  advance;

    // Pipeline handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_data_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boiler_setpoint <= RST_BOILER_SP;
            cfg_reg.steam_setpoint  <= RST_STEAM_SP;
            cfg_reg.brew_pressure   <= RST_BREW_PRESS;
            cfg_reg.bloom_fill_ms   <= '0;
            cfg_reg.bloom_wait_ms   <= '0;
            cfg_reg.bloom_pressure  <= '0;
            cfg_reg.brew_time_ms    <= '0;
            cfg_reg.steam_press_cap <= RST_STEAM_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BOILER_SP:   cfg_reg.boiler_setpoint <= cfg_wdata[10:0];
                CFG_STEAM_SP:    cfg_reg.steam_setpoint  <= cfg_wdata[10:0];
                CFG_BREW_PRESS:  cfg_reg.brew_pressure   <= cfg_wdata[7:0];
                CFG_BLOOM_FILL:  cfg_reg.bloom_fill_ms   <= cfg_wdata;
                CFG_BLOOM_WAIT:  cfg_reg.bloom_wait_ms   <= cfg_wdata;
                CFG_BLOOM_PRESS: cfg_reg.bloom_pressure  <= cfg_wdata[7:0];
                CFG_BREW_TIME:   cfg_reg.brew_time_ms    <= cfg_wdata;
                CFG_STEAM_MAX:   cfg_reg.steam_press_cap <= cfg_wdata[7:0];
                default:         cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Sequencer core
    bps_step #(
        .STEAM_PUMP_PCT (STEAM_PUMP_PCT),
        .TIME_BITS      (TIME_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

endmodule

[rtl/core/bps_step.sv]
module bps_step #(
    parameter int STEAM_PUMP_PCT = bps_pkg::DEF_STEAM_PUMP_PCT,
    parameter int TIME_BITS      = bps_pkg::DEF_TIME_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  bps_pkg::in_t  item,
    input  bps_pkg::cfg_t cfg,
    output bps_pkg::out_t result
);
    import bps_pkg::*;

    localparam int TW = TIME_BITS;
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [6:0] PUMP_PCT = 7'(STEAM_PUMP_PCT);

    // Sequencer state
    logic [1:0]    phase_reg, phase_next;
    logic          brew_running_reg, brew_running_next;
    logic [TW-1:0] brew_started_reg, brew_started_next;
    logic [TW-1:0] phase_started_reg, phase_started_next;
    logic [TW-1:0] action_started_reg, action_started_next;
    logic [TW-1:0] action_stopped_reg, action_stopped_next;
    logic [TW-1:0] last_shot_reg, last_shot_next;

    logic [TW-1:0] now_w;
    logic [TW-1:0] elapsed;
    logic [CW-1:0] elapsed_x, fill_x, wait_x, brew_x;
    logic [31:0]   start_out, stop_out, shot_out;
    logic [10:0]   temp_w;
    logic          bloom_ok;
    out_t          res;

    // Brew-type set point: pressure zero means off
    function automatic out_t sp_brew(input logic [10:0] t, input logic [7:0] p);
        out_t r;
        r           = '0;
        r.valid_res = 1'b1;
        r.mode      = (p != 8'd0) ? MODE_BREW : MODE_OFF;
        r.temp_set  = t;
        r.press_set = p;
        return r;
    endfunction

    assign elapsed = now_w - phase_started_reg;

    // Width adaptation between the 32-bit ports and the time state
    generate
        if (TW > 32)
        begin : g_wide
            assign now_w     = {{(TW-32){1'b0}}, item.now_ms};
            assign elapsed_x = elapsed;
            assign fill_x    = {{(CW-32){1'b0}}, cfg.bloom_fill_ms};
            assign wait_x    = {{(CW-32){1'b0}}, cfg.bloom_wait_ms};
            assign brew_x    = {{(CW-32){1'b0}}, cfg.brew_time_ms};
            assign start_out = action_started_next[31:0];
            assign stop_out  = action_stopped_next[31:0];
            assign shot_out  = last_shot_next[31:0];
        end
        else if (TW == 32)
        begin : g_same
            assign now_w     = item.now_ms;
            assign elapsed_x = elapsed;
            assign fill_x    = cfg.bloom_fill_ms;
            assign wait_x    = cfg.bloom_wait_ms;
            assign brew_x    = cfg.brew_time_ms;
            assign start_out = action_started_next;
            assign stop_out  = action_stopped_next;
            assign shot_out  = last_shot_next;
        end
        else
        begin : g_narrow
            assign now_w     = item.now_ms[TW-1:0];
            assign elapsed_x = {{(CW-TW){1'b0}}, elapsed};
            assign fill_x    = cfg.bloom_fill_ms;
            assign wait_x    = cfg.bloom_wait_ms;
            assign brew_x    = cfg.brew_time_ms;
            assign start_out = {{(32-TW){1'b0}}, action_started_next};
            assign stop_out  = {{(32-TW){1'b0}}, action_stopped_next};
            assign shot_out  = {{(32-TW){1'b0}}, last_shot_next};
        end
    endgenerate

    assign bloom_ok = (cfg.bloom_fill_ms != 32'd0) && (cfg.bloom_wait_ms != 32'd0)
                   && (cfg.bloom_pressure != 8'd0);

    assign temp_w = item.boiler_on ? cfg.boiler_setpoint
                  : (item.steaming ? cfg.steam_setpoint : 11'd0);

    // Command decode and phase timing
    always_comb
    begin
        phase_next          = phase_reg;
        brew_running_next   = brew_running_reg;
        brew_started_next   = brew_started_reg;
        phase_started_next  = phase_started_reg;
        action_started_next = action_started_reg;
        action_stopped_next = action_stopped_reg;
        last_shot_next      = last_shot_reg;
        res                 = '0;

        if (item.changed)
        begin
            if (item.want_brew)
            begin
                action_started_next = now_w;
                action_stopped_next = '0;
                phase_started_next  = now_w;
                brew_started_next   = now_w;
                brew_running_next   = 1'b1;
                res = sp_brew(temp_w, cfg.brew_pressure);
            end
            else if (item.want_clean)
            begin
                action_started_next = now_w;
                action_stopped_next = '0;
                phase_started_next  = now_w;
                res.valid_res = 1'b1;
                res.mode      = MODE_CLEAN;
                res.temp_set  = temp_w;
                res.press_set = CLEAN_PRESSURE;
            end
            else if (item.want_bloom)
            begin
                if (phase_reg == PH_OFF)
                begin
                    if (bloom_ok)
                    begin
                        phase_next          = PH_FILL;
                        action_started_next = now_w;
                        action_stopped_next = '0;
                        phase_started_next  = now_w;
                        res = sp_brew(temp_w, cfg.bloom_pressure);
                    end
                    else
                    begin
                        res.clear_bloom = 1'b1;
                    end
                end
            end
            else if (item.want_auto)
            begin
                if (phase_reg == PH_OFF)
                begin
                    if (cfg.brew_time_ms != 32'd0)
                    begin
                        action_started_next = now_w;
                        action_stopped_next = '0;
                        phase_started_next  = now_w;
                        if (bloom_ok)
                        begin
                            phase_next = PH_FILL;
                            res = sp_brew(temp_w, cfg.bloom_pressure);
                        end
                        else
                        begin
                            phase_next        = PH_BREW;
                            brew_started_next = now_w;
                            brew_running_next = 1'b1;
                            res = sp_brew(temp_w, cfg.brew_pressure);
                        end
                    end
                    else
                    begin
                        res.clear_auto = 1'b1;
                    end
                end
            end
            else if (item.steaming)
            begin
                if (action_started_reg != '0 && action_stopped_reg == '0)
                begin
                    action_stopped_next = now_w;
                end
                res.valid_res = 1'b1;
                res.mode      = MODE_STEAM;
                res.temp_set  = cfg.steam_setpoint;
                res.press_set = cfg.steam_press_cap;
                res.pump_pct  = PUMP_PCT;
            end
            else
            begin
                // stop: record shot, stamp stop, back to off
                if (brew_running_reg)
                begin
                    brew_running_next = 1'b0;
                    last_shot_next    = now_w - brew_started_reg;
                end
                if (action_started_reg != '0 && action_stopped_reg == '0)
                begin
                    action_stopped_next = now_w;
                end
                phase_next = PH_OFF;
                res = sp_brew(item.boiler_on ? cfg.boiler_setpoint : 11'd0, 8'd0);
            end
        end
        else
        begin
            case (phase_reg)
                PH_FILL:
                begin
                    if (elapsed_x > fill_x)
                    begin
                        phase_next         = PH_WAIT;
                        phase_started_next = now_w;
                        res = sp_brew(temp_w, 8'd0);
                    end
                end
                PH_WAIT:
                begin
                    if (elapsed_x > wait_x)
                    begin
                        if (item.want_bloom)
                        begin
                            phase_next          = PH_OFF;
                            action_stopped_next = now_w;
                            res.clear_bloom     = 1'b1;
                        end
                        else if (item.want_auto)
                        begin
                            phase_next         = PH_BREW;
                            phase_started_next = now_w;
                            brew_started_next  = now_w;
                            brew_running_next  = 1'b1;
                            res = sp_brew(temp_w, cfg.brew_pressure);
                        end
                    end
                end
                PH_BREW:
                begin
                    if (elapsed_x > brew_x)
                    begin
                        phase_next          = PH_OFF;
                        action_stopped_next = now_w;
                        res.clear_auto      = 1'b1;
                        if (brew_running_reg)
                        begin
                            brew_running_next = 1'b0;
                            last_shot_next    = now_w - brew_started_reg;
                        end
                        res = sp_brew(temp_w, 8'd0);
                        res.clear_auto = 1'b1;
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    // Status fields reflect state after this request
    always_comb
    begin
        result                 = res;
        result.phase           = phase_next;
        result.action_start_ms = start_out;
        result.action_stop_ms  = stop_out;
        result.last_shot_ms    = shot_out;
    end

    // State update on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_OFF;
            brew_running_reg   <= 1'b0;
            brew_started_reg   <= '0;
            phase_started_reg  <= '0;
            action_started_reg <= '0;
            action_stopped_reg <= '0;
            last_shot_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            brew_running_reg   <= brew_running_next;
            brew_started_reg   <= brew_started_next;
            phase_started_reg  <= phase_started_next;
            action_started_reg <= action_started_next;
            action_stopped_reg <= action_stopped_next;
            last_shot_reg      <= last_shot_next;
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int PRESSURE_ITEMS = 60;
    localparam int HOLD_CYCLES    = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_t result;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Shadow of the register file
    cfg_t cfg_now = '{boiler_setpoint: RST_BOILER_SP, steam_setpoint: RST_STEAM_SP,
                      brew_pressure: RST_BREW_PRESS, bloom_fill_ms: 32'd0,
                      bloom_wait_ms: 32'd0, bloom_pressure: 8'd0, brew_time_ms: 32'd0,
                      steam_press_cap: RST_STEAM_MAX};

    // Sequencer state as seen by the predictor
    logic [1:0]  cur_phase = PH_OFF;
    logic        shot_running = 1'b0;
    logic [31:0] shot_t0 = '0;
    logic [31:0] phase_t0 = '0;
    logic [31:0] act_start = '0;
    logic [31:0] act_stop = '0;
    logic [31:0] shot_len = '0;

    out_t setpoint_q[$];
    out_t want_res;
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   rx_hold_cycles = 0;
    int   stall_cycles = 0;
    bit   tx_gaps_on = 1'b1;
    bit   rx_stalls_on = 1'b1;
    bit   req_held = 1'b0;
    logic [31:0] ms_clock = '0;

    brew_phase_sequencer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic out_t brew_point(logic [10:0] t, logic [7:0] p);
        out_t o;
        o = '0;
        o.valid_res = 1'b1;
        o.mode      = (p != 0) ? MODE_BREW : MODE_OFF;
        o.temp_set  = t;
        o.press_set = p;
        return o;
    endfunction

    function automatic void open_action(logic [31:0] t);
        act_start = t;
        act_stop   = '0;
        phase_t0   = t;
    endfunction

    function automatic void close_action(logic [31:0] t);
        if (act_start != 0 && act_stop == 0)
            act_stop = t;
    endfunction

    function automatic void open_shot(logic [31:0] t);
        shot_t0      = t;
        shot_running = 1'b1;
    endfunction

    function automatic void close_shot(logic [31:0] t);
        if (shot_running)
        begin
            shot_running = 1'b0;
            shot_len     = t - shot_t0;
        end
    endfunction

    function automatic out_t next_setpoints(in_t q);
        out_t        o;
        logic [10:0] temp;
        logic [31:0] elapsed;
        logic        bloom_ok;
        logic        clr_b;
        logic        clr_a;
        o        = '0;
        clr_b    = 1'b0;
        clr_a    = 1'b0;
        temp     = q.boiler_on ? cfg_now.boiler_setpoint :
                   (q.steaming ? cfg_now.steam_setpoint : 11'd0);
        elapsed  = q.now_ms - phase_t0;
        bloom_ok = cfg_now.bloom_fill_ms != 0 && cfg_now.bloom_wait_ms != 0 &&
                   cfg_now.bloom_pressure != 0;
        if (q.changed)
        begin
            // command change, flags in priority order
            if (q.want_brew)
            begin
                open_action(q.now_ms);
                open_shot(q.now_ms);
                o = brew_point(temp, cfg_now.brew_pressure);
            end
            else if (q.want_clean)
            begin
                open_action(q.now_ms);
                o.valid_res = 1'b1;
                o.mode      = MODE_CLEAN;
                o.temp_set  = temp;
                o.press_set = CLEAN_PRESSURE;
            end
            else if (q.want_bloom)
            begin
                if (cur_phase == PH_OFF)
                begin
                    if (bloom_ok)
                    begin
                        cur_phase = PH_FILL;
                        open_action(q.now_ms);
                        o = brew_point(temp, cfg_now.bloom_pressure);
                    end
                    else
                        clr_b = 1'b1;
                end
            end
            else if (q.want_auto)
            begin
                if (cur_phase == PH_OFF)
                begin
                    if (cfg_now.brew_time_ms != 0)
                    begin
                        open_action(q.now_ms);
                        if (bloom_ok)
                        begin
                            cur_phase = PH_FILL;
                            o = brew_point(temp, cfg_now.bloom_pressure);
                        end
                        else
                        begin
                            cur_phase = PH_BREW;
                            open_shot(q.now_ms);
                            o = brew_point(temp, cfg_now.brew_pressure);
                        end
                    end
                    else
                        clr_a = 1'b1;
                end
            end
            else if (q.steaming)
            begin
                close_action(q.now_ms);
                o.valid_res = 1'b1;
                o.mode      = MODE_STEAM;
                o.temp_set  = cfg_now.steam_setpoint;
                o.press_set = cfg_now.steam_press_cap;
                o.pump_pct  = 7'(DEF_STEAM_PUMP_PCT);
            end
            else
            begin
                close_shot(q.now_ms);
                close_action(q.now_ms);
                cur_phase = PH_OFF;
                o = brew_point(q.boiler_on ? cfg_now.boiler_setpoint : 11'd0, 8'd0);
            end
        end
        else
        begin
            // timing tick
            case (cur_phase)
                PH_FILL:
                begin
                    if (elapsed > cfg_now.bloom_fill_ms)
                    begin
                        cur_phase = PH_WAIT;
                        phase_t0  = q.now_ms;
                        o = brew_point(temp, 8'd0);
                    end
                end
                PH_WAIT:
                begin
                    if (elapsed > cfg_now.bloom_wait_ms)
                    begin
                        if (q.want_bloom)
                        begin
                            cur_phase = PH_OFF;
                            act_stop  = q.now_ms;
                            clr_b     = 1'b1;
                        end
                        else if (q.want_auto)
                        begin
                            cur_phase = PH_BREW;
                            phase_t0  = q.now_ms;
                            open_shot(q.now_ms);
                            o = brew_point(temp, cfg_now.brew_pressure);
                        end
                    end
                end
                PH_BREW:
                begin
                    if (elapsed > cfg_now.brew_time_ms)
                    begin
                        cur_phase = PH_OFF;
                        act_stop  = q.now_ms;
                        clr_a     = 1'b1;
                        close_shot(q.now_ms);
                        o = brew_point(temp, 8'd0);
                    end
                end
                default: ;
            endcase
        end
        o.clear_bloom     = clr_b;
        o.clear_auto      = clr_a;
        o.phase           = cur_phase;
        o.action_start_ms = act_start;
        o.action_stop_ms  = act_stop;
        o.last_shot_ms    = shot_len;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic in_t make_req(logic [31:0] t, logic chg, logic brew, logic clean,
                                     logic bloom, logic auto_f, logic steam, logic boiler);
        in_t r;
        r.now_ms     = t;
        r.changed    = chg;
        r.want_brew  = brew;
        r.want_clean = clean;
        r.want_bloom = bloom;
        r.want_auto  = auto_f;
        r.steaming   = steam;
        r.boiler_on  = boiler;
        return r;
    endfunction

    task automatic send_req(input in_t r);
        int gap;
        item       <= r;
        item_valid <= 1'b1;
        req_held    = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        setpoint_q.push_back(next_setpoints(r));
        items_sent++;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            req_held    = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every expected result is back
    task automatic drain_pipe();
        if (req_held)
        begin
            item_valid <= 1'b0;
            req_held    = 1'b0;
        end
        while (setpoint_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOILER_SP:   cfg_now.boiler_setpoint = val[10:0];
            CFG_STEAM_SP:    cfg_now.steam_setpoint  = val[10:0];
            CFG_BREW_PRESS:  cfg_now.brew_pressure   = val[7:0];
            CFG_BLOOM_FILL:  cfg_now.bloom_fill_ms   = val;
            CFG_BLOOM_WAIT:  cfg_now.bloom_wait_ms   = val;
            CFG_BLOOM_PRESS: cfg_now.bloom_pressure  = val[7:0];
            CFG_BREW_TIME:   cfg_now.brew_time_ms    = val;
            CFG_STEAM_MAX:   cfg_now.steam_press_cap = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_level(int unsigned hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return hi;
        return $urandom_range(1, hi);
    endfunction

    function automatic logic [31:0] pick_span();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 32'd0;
        if (r == 2)
            return 32'hFFFF_FFFF;
        return $urandom_range(1, 250);
    endfunction

    task automatic apply_random_setting();
        int r;
        write_reg(CFG_BOILER_SP, pick_level(1600));
        write_reg(CFG_STEAM_SP, pick_level(1600));
        write_reg(CFG_BREW_PRESS, pick_level(150));
        write_reg(CFG_BLOOM_FILL, pick_span());
        write_reg(CFG_BLOOM_WAIT, pick_span());
        write_reg(CFG_BLOOM_PRESS, pick_level(150));
        write_reg(CFG_BREW_TIME, pick_span());
        write_reg(CFG_STEAM_MAX, pick_level(150));
        // restart the millisecond clock, sometimes right before the wrap
        r = $urandom_range(0, 3);
        if (r == 0)
            ms_clock = $urandom;
        else if (r == 1)
            ms_clock = 32'hFFFF_FF00 + $urandom_range(0, 200);
        else
            ms_clock = $urandom_range(0, 50);
    endtask

    function automatic logic [31:0] pick_step();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 400);
        return $urandom_range(0, 40);
    endfunction

    // one command followed by the ticks that drive it through its phases
    task automatic run_sequence();
        int   kind;
        int   n;
        logic boiler;
        logic steam;
        logic bloom_f;
        logic auto_f;
        in_t  r;
        kind    = $urandom_range(0, 9);
        boiler  = coin();
        steam   = coin();
        bloom_f = (kind == 3 || kind == 4);
        auto_f  = (kind <= 2);
        ms_clock += $urandom_range(0, 40);
        r = make_req(ms_clock, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, steam, boiler);
        case (kind)
            0, 1, 2: r.want_auto = 1'b1;
            3, 4:
            begin
                r.want_bloom = 1'b1;
                r.want_auto  = coin();
            end
            5:
            begin
                r.want_brew  = 1'b1;
                r.want_clean = coin();
                r.want_bloom = coin();
                r.want_auto  = coin();
            end
            6:
            begin
                r.want_clean = 1'b1;
                r.want_bloom = coin();
                r.want_auto  = coin();
            end
            7: r.steaming = 1'b1;
            8: r.steaming = 1'b0;
            default:
            begin
                r.want_brew  = coin();
                r.want_clean = coin();
                r.want_bloom = coin();
                r.want_auto  = coin();
            end
        endcase
        send_req(r);
        n = $urandom_range(2, 16);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // noise: any time stamp, any flags
                r = in_t'({$urandom, 7'($urandom_range(0, 127))});
            end
            else
            begin
                ms_clock += pick_step();
                if ($urandom_range(0, 15) == 0)
                    boiler = ~boiler;
                if ($urandom_range(0, 15) == 0)
                    steam = ~steam;
                r = make_req(ms_clock, 1'b0, coin(), coin(), bloom_f, auto_f, steam, boiler);
                if ($urandom_range(0, 9) == 0)
                begin
                    r.want_bloom = coin();
                    r.want_auto  = coin();
                end
                if ($urandom_range(0, 19) == 0)
                    r.changed = 1'b1;
            end
            send_req(r);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            ms_clock += pick_step();
            send_req(make_req(ms_clock, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, boiler));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // reset defaults: no bloom, no auto brew time
    task automatic test_default_commands();
        send_req(make_req(32'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // start stamp is zero, so stop records no stop stamp
        send_req(make_req(32'd100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_req(make_req(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_req(make_req(32'd5, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_req(make_req(32'd6, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_req(make_req(32'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_req(make_req(32'd9, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        drain_pipe();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_BOILER_SP, 32'd1600);
        write_reg(CFG_STEAM_SP, 32'd0);
        write_reg(CFG_BREW_PRESS, 32'd0);
        write_reg(CFG_BLOOM_FILL, 32'hFFFF_FFFF);
        write_reg(CFG_BLOOM_WAIT, 32'hFFFF_FFFF);
        write_reg(CFG_BLOOM_PRESS, 32'd150);
        write_reg(CFG_BREW_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_STEAM_MAX, 32'd150);
        // zero brew pressure gives mode off
        send_req(make_req(32'd20, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_req(make_req(32'd21, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        // elapsed wraps to all ones, still not past the longest fill
        send_req(make_req(32'd20, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        // auto while a phase runs is ignored
        send_req(make_req(32'd30, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_req(make_req(32'd40, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        drain_pipe();
        write_reg(CFG_BOILER_SP, 32'd0);
        write_reg(CFG_STEAM_SP, 32'd1600);
        write_reg(CFG_BREW_PRESS, 32'd150);
        write_reg(CFG_BLOOM_FILL, 32'd0);
        write_reg(CFG_BREW_TIME, 32'd1);
        write_reg(CFG_STEAM_MAX, 32'd0);
        // auto without bloom goes straight to brew
        send_req(make_req(32'd50, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_req(make_req(32'd51, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_req(make_req(32'd52, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        // stop stamp already recorded, steam keeps it
        send_req(make_req(32'd53, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        drain_pipe();
    endtask

    task automatic test_timed_phases();
        write_reg(CFG_BOILER_SP, 32'd930);
        write_reg(CFG_BLOOM_FILL, 32'd10);
        write_reg(CFG_BLOOM_WAIT, 32'd20);
        write_reg(CFG_BLOOM_PRESS, 32'd40);
        write_reg(CFG_BREW_TIME, 32'd30);
        write_reg(CFG_BREW_PRESS, 32'd90);
        write_reg(CFG_STEAM_MAX, 32'd20);
        send_req(make_req(32'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // elapsed equal to the limit does not advance
        send_req(make_req(32'd1010, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_req(make_req(32'd1011, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // wait over with neither flag: holds
        send_req(make_req(32'd1040, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // clean during a phase renews the stamps and leaves the phase as it is
        send_req(make_req(32'd1041, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_req(make_req(32'd1062, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // manual brew inside the brew phase
        send_req(make_req(32'd1070, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_req(make_req(32'd1101, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // bloom only run ends with a clear pulse
        send_req(make_req(32'd1200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_req(make_req(32'd1211, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_req(make_req(32'd1232, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        drain_pipe();
    endtask

    task automatic test_random_traffic();
        int target;
        int next_setting;
        bit first;
        target       = items_sent + RANDOM_ITEMS;
        next_setting = items_sent;
        first        = 1'b1;
        while (items_sent < target)
        begin
            if (items_sent >= next_setting)
            begin
                drain_pipe();
                apply_random_setting();
                // the first stretch runs with no idling at all
                tx_gaps_on   = first ? 1'b0 : ($urandom_range(0, 3) != 0);
                rx_stalls_on = first ? 1'b0 : ($urandom_range(0, 3) != 0);
                first        = 1'b0;
                next_setting = items_sent + 150;
            end
            run_sequence();
        end
        drain_pipe();
    endtask

    // receiver stops for a long while, sender keeps pushing
    task automatic test_output_backpressure();
        int target;
        tx_gaps_on     = 1'b0;
        rx_stalls_on   = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        target         = items_sent + PRESSURE_ITEMS;
        while (items_sent < target)
            run_sequence();
        drain_pipe();
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                result_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                result_ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (setpoint_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, result);
                mismatch_count++;
            end
            else
            begin
                want_res = setpoint_q.pop_front();
                if (want_res !== result)
                begin
                    $display("%0t: result mismatch, expected %p, got %p",
                             $time, want_res, result);
                    mismatch_count++;
                end
            end
        end
    end

    // no progress on either channel for too long ends the run
    initial
    begin
        wait (rst_n);
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_commands();
        test_config_extremes();
        test_timed_phases();
        test_random_traffic();
        test_output_backpressure();
        drain_pipe();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
